[rtl/msfdl_pkg.sv]
// Shared constants, types and states of the multi-source fractional delay line.
// Used by multi_source_fractional_delay_line_unit; depends on nothing else.
`default_nettype none

package msfdl_pkg;

    localparam int NUM_SOURCES_DEF = 16;
    localparam int RING_LEN_DEF    = 256;

    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 40;
    localparam int SRC_W     = 4;
    localparam int VAL_W     = 32;
    localparam int DEL_W     = 24;
    localparam int GRID_W    = 24;
    localparam int IN_DATA_W = 104;
    localparam int DVD_W     = 49;
    localparam int PROD_W    = 50;
    localparam int W_W       = 42;
    localparam int CNT_W     = 6;

    localparam int MOD_STEPS = GRID_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int MUL_STEPS = FRAC_BITS + 1;

    typedef enum logic [0:0] {
        MODE_UPDATE = 1'b0,
        MODE_QUERY  = 1'b1
    } t_mode;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_GRID,
        ST_U_MOD,
        ST_U_POS,
        ST_U_READ,
        ST_U_X0,
        ST_U_DIV,
        ST_U_WR,
        ST_Q_W0,
        ST_Q_W1,
        ST_Q_CLAMP,
        ST_Q_IDX,
        ST_Q_RD0,
        ST_Q_RD1,
        ST_Q_RD2,
        ST_Q_MUL,
        ST_Q_SUM,
        ST_Q_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/multi_source_fractional_delay_line_unit.sv]
// Multi-source fractional delay line with linear interpolation, top level.
// Depends on msfdl_pkg for constants, the mode type and the state type.
`default_nettype none

// After reset the block clears its sample store, one entry per cycle, before it
// takes the first item; configuration writes are taken during that pass. Items are
// handled one at a time, and the input is ready again once the block is back in its
// idle state after an item is finished. A query runs through the 17-step serial
// multiplier before its result is held in the output register, and skips the reads
// and the multiply when its source is out of range. An update whose time lies on or
// before the grid point reached is written directly; one that lands exactly on a new
// grid point first moves the grid; one that lies between the grid point reached and
// the next one goes through the divider; one that moves the grid and falls between
// grid points does both. The grid move uses a bit-serial reduction of the grid
// advance modulo RING_LEN, and the extrapolation a bit-serial restoring divider. An
// update to a source out of range ends after the grid move. A finished result waits
// in the output register while the next item is accepted.
module multi_source_fractional_delay_line_unit
    import msfdl_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF,
    parameter int RING_LEN    = RING_LEN_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_wdata,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // tdata from bit 0: time_req[39:0], source[43:40], sample_value[75:44],
    // delay[99:76], zero fill[103:100].
    input  wire [IN_DATA_W-1:0]  i_s_tdata,
    // tuser: mode (0 update, 1 query).
    input  wire                  i_s_tuser,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // tdata: delayed_value[31:0].
    output logic [VAL_W-1:0]     o_m_tdata
);

    localparam int DEPTH = NUM_SOURCES * RING_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(RING_LEN);
    localparam int VW    = RW + FRAC_BITS + 1;
    localparam logic [RW:0] RL1 = (RW + 1)'(RING_LEN);
    localparam logic [RW-1:0] RING_LAST = RW'(RING_LEN - 1);
    localparam logic signed [W_W-1:0] V_LO = -(W_W'(1) <<< FRAC_BITS);
    localparam logic signed [W_W-1:0] V_HI = W_W'(RING_LEN - 2) <<< FRAC_BITS;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rd;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_clr, n_clr;
    logic                     r_round, n_round;
    logic [GRID_W-1:0]        r_grid, n_grid;
    logic [RW-1:0]            r_pos, n_pos;
    logic [TIME_W-1:0]        r_t, n_t;
    logic [VAL_W-1:0]         r_val, n_val;
    logic [DEL_W-1:0]         r_dly, n_dly;
    logic [AW-1:0]            r_base, n_base;
    logic                     r_src_ok, n_src_ok;
    logic                     r_fpos, n_fpos;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [GRID_W-1:0]        r_msr, n_msr;
    logic [RW-1:0]            r_mrem, n_mrem;
    logic signed [VAL_W-1:0]  r_x0, n_x0;
    logic [DVD_W-1:0]         r_dvd, n_dvd;
    logic [FRAC_BITS-1:0]     r_rem, n_rem;
    logic                     r_neg, n_neg;
    logic signed [W_W-1:0]    r_w, n_w;
    logic signed [VW-1:0]     r_v, n_v;
    logic [RW-1:0]            r_i0, n_i0;
    logic [RW-1:0]            r_i1, n_i1;
    logic [FRAC_BITS:0]       r_dx, n_dx;
    logic signed [PROD_W-1:0] r_mcand, n_mcand;
    logic [FRAC_BITS:0]       r_mplr, n_mplr;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0]         r_res, n_res;
    logic                     r_o_tvalid, n_o_tvalid;
    logic [VAL_W-1:0]         r_o_tdata, n_o_tdata;

    logic [SRC_W-1:0]         in_src;
    logic [GRID_W-1:0]        whole;
    logic [RW:0]              mod_try;
    logic [FRAC_BITS:0]       div_try;
    logic signed [VAL_W:0]    upd_diff;
    logic [VAL_W:0]           upd_mag;
    logic signed [PROD_W-1:0] quot;
    logic signed [PROD_W:0]   upd_sum;
    logic [VAL_W-1:0]         upd_sat;
    logic [DEL_W:0]           del_round;
    logic [DEL_W:0]           del_eff;
    logic [RW-1:0]            k0;
    logic [RW-1:0]            k1;
    logic [RW:0]              s0;
    logic [RW:0]              s1;
    logic signed [VAL_W:0]    q_diff;
    logic signed [PROD_W-FRAC_BITS-1:0] q_step;
    logic signed [PROD_W-FRAC_BITS:0]   q_sum;
    logic [VAL_W-1:0]         q_sat;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_o_tvalid;
    assign o_m_tdata  = r_o_tdata;

    assign in_src = i_s_tdata[43:40];
    assign whole  = r_t[TIME_W-1:FRAC_BITS];

    assign mod_try = {r_mrem, r_msr[GRID_W-1]};
    assign div_try = {r_rem, r_dvd[DVD_W-1]};

    assign upd_diff = $signed({r_val[VAL_W-1], r_val}) - $signed({r_rd[VAL_W-1], r_rd});
    assign upd_mag  = upd_diff[VAL_W] ? (VAL_W + 1)'(-upd_diff) : upd_diff;
    assign quot     = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
    assign upd_sum  = (PROD_W + 1)'(quot) + (PROD_W + 1)'(r_x0);

    always_comb begin
        if (upd_sum > (PROD_W + 1)'(32'sh7FFF_FFFF)) begin
            upd_sat = 32'h7FFF_FFFF;
        end else if (upd_sum < -(PROD_W + 1)'(33'sh0_8000_0000)) begin
            upd_sat = 32'h8000_0000;
        end else begin
            upd_sat = upd_sum[VAL_W-1:0];
        end
    end

    assign del_round = {(DEL_W + 1)'(r_dly) + (DEL_W + 1)'(1 << (FRAC_BITS - 1))}
                       & ~(DEL_W + 1)'((1 << FRAC_BITS) - 1);
    assign del_eff   = r_round ? del_round : {1'b0, r_dly};

    assign k0 = (r_v > 0) ? RW'(r_v[VW-1:FRAC_BITS] + (RW + 1)'(r_v[FRAC_BITS-1:0] != 0))
                          : '0;
    assign k1 = (k0 == '0) ? RING_LAST : k0 - RW'(1);
    assign s0 = {1'b0, r_pos} + {1'b0, k0};
    assign s1 = {1'b0, r_pos} + {1'b0, k1};

    assign q_diff = $signed({r_rd[VAL_W-1], r_rd}) - $signed({r_x0[VAL_W-1], r_x0});
    assign q_step = r_acc[PROD_W-1:FRAC_BITS];
    assign q_sum  = (PROD_W - FRAC_BITS + 1)'(q_step) + (PROD_W - FRAC_BITS + 1)'(r_x0);

    always_comb begin
        if (q_sum > (PROD_W - FRAC_BITS + 1)'(32'sh7FFF_FFFF)) begin
            q_sat = 32'h7FFF_FFFF;
        end else if (q_sum < -(PROD_W - FRAC_BITS + 1)'(33'sh0_8000_0000)) begin
            q_sat = 32'h8000_0000;
        end else begin
            q_sat = q_sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_round    <= 1'b0;
            r_grid     <= '0;
            r_pos      <= '0;
            r_o_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_round    <= n_round;
            r_grid     <= n_grid;
            r_pos      <= n_pos;
            r_o_tvalid <= n_o_tvalid;
        end
        r_t       <= n_t;
        r_val     <= n_val;
        r_dly     <= n_dly;
        r_base    <= n_base;
        r_src_ok  <= n_src_ok;
        r_fpos    <= n_fpos;
        r_cnt     <= n_cnt;
        r_msr     <= n_msr;
        r_mrem    <= n_mrem;
        r_x0      <= n_x0;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_w       <= n_w;
        r_v       <= n_v;
        r_i0      <= n_i0;
        r_i1      <= n_i1;
        r_dx      <= n_dx;
        r_mcand   <= n_mcand;
        r_mplr    <= n_mplr;
        r_acc     <= n_acc;
        r_res     <= n_res;
        r_o_tdata <= n_o_tdata;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_round    = i_cfg_we ? i_cfg_wdata : r_round;
        n_grid     = r_grid;
        n_pos      = r_pos;
        n_t        = r_t;
        n_val      = r_val;
        n_dly      = r_dly;
        n_base     = r_base;
        n_src_ok   = r_src_ok;
        n_fpos     = r_fpos;
        n_cnt      = r_cnt;
        n_msr      = r_msr;
        n_mrem     = r_mrem;
        n_x0       = r_x0;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_neg      = r_neg;
        n_w        = r_w;
        n_v        = r_v;
        n_i0       = r_i0;
        n_i1       = r_i1;
        n_dx       = r_dx;
        n_mcand    = r_mcand;
        n_mplr     = r_mplr;
        n_acc      = r_acc;
        n_res      = r_res;
        n_o_tvalid = (r_o_tvalid && i_m_tready) ? 1'b0 : r_o_tvalid;
        n_o_tdata  = r_o_tdata;
        mem_we     = 1'b0;
        mem_waddr  = r_base + AW'(r_i0);
        mem_wdata  = r_val;
        mem_raddr  = r_base + AW'(r_i0);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_t      = i_s_tdata[39:0];
                    n_val    = i_s_tdata[75:44];
                    n_dly    = i_s_tdata[99:76];
                    n_src_ok = {{(32 - SRC_W){1'b0}}, in_src} < 32'(NUM_SOURCES);
                    n_base   = AW'(AW'(in_src) * AW'(RING_LEN));
                    n_state  = (i_s_tuser == MODE_QUERY) ? ST_Q_W0 : ST_U_GRID;
                end
            end
            ST_U_GRID: begin
                n_fpos = (whole >= r_grid) && (r_t[FRAC_BITS-1:0] != '0);
                n_msr  = whole - r_grid;
                n_mrem = '0;
                n_cnt  = '0;
                n_state = (whole > r_grid) ? ST_U_MOD : ST_U_READ;
            end
            ST_U_MOD: begin
                n_msr  = {r_msr[GRID_W-2:0], 1'b0};
                n_mrem = (mod_try >= RL1) ? RW'(mod_try - RL1) : RW'(mod_try);
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                    n_state = ST_U_POS;
                end
            end
            ST_U_POS: begin
                n_grid = whole;
                n_pos  = (r_pos >= r_mrem) ? r_pos - r_mrem
                                           : RW'({1'b0, r_pos} + RL1 - {1'b0, r_mrem});
                n_state = ST_U_READ;
            end
            ST_U_READ: begin
                n_i0      = r_pos;
                n_i1      = (r_pos == '0) ? RING_LAST : r_pos - RW'(1);
                mem_raddr = r_base + AW'(r_pos);
                n_state   = r_src_ok ? ST_U_X0 : ST_IDLE;
            end
            ST_U_X0: begin
                if (!r_fpos) begin
                    mem_we  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_x0    = r_rd;
                    n_neg   = upd_diff[VAL_W];
                    n_dvd   = {upd_mag, {FRAC_BITS{1'b0}}};
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_U_DIV;
                end
            end
            ST_U_DIV: begin
                if (div_try >= {1'b0, r_t[FRAC_BITS-1:0]}) begin
                    n_rem = FRAC_BITS'(div_try - {1'b0, r_t[FRAC_BITS-1:0]});
                    n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
                end else begin
                    n_rem = FRAC_BITS'(div_try);
                    n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_U_WR;
                end
            end
            ST_U_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_base + AW'(r_i1);
                mem_wdata = upd_sat;
                n_state   = ST_IDLE;
            end
            ST_Q_W0: begin
                n_w     = $signed({2'b00, r_grid, {FRAC_BITS{1'b0}}}) - $signed({2'b00, r_t});
                n_state = ST_Q_W1;
            end
            ST_Q_W1: begin
                n_w     = r_w + $signed({{(W_W - DEL_W - 1){1'b0}}, del_eff});
                n_state = ST_Q_CLAMP;
            end
            ST_Q_CLAMP: begin
                if (r_w < V_LO) begin
                    n_v = VW'(V_LO);
                end else if (r_w > V_HI) begin
                    n_v = VW'(V_HI);
                end else begin
                    n_v = VW'(r_w);
                end
                n_state = ST_Q_IDX;
            end
            ST_Q_IDX: begin
                if (!r_src_ok) begin
                    n_res   = '0;
                    n_state = ST_Q_OUT;
                end else begin
                    n_dx    = (r_v <= 0) ? (FRAC_BITS + 1)'(-r_v)
                                         : {1'b0, FRAC_BITS'(~r_v[FRAC_BITS-1:0] + 1'b1)};
                    n_i0    = (s0 >= RL1) ? RW'(s0 - RL1) : RW'(s0);
                    n_i1    = (s1 >= RL1) ? RW'(s1 - RL1) : RW'(s1);
                    n_state = ST_Q_RD0;
                end
            end
            ST_Q_RD0: begin
                mem_raddr = r_base + AW'(r_i0);
                n_state   = ST_Q_RD1;
            end
            ST_Q_RD1: begin
                mem_raddr = r_base + AW'(r_i1);
                n_x0      = r_rd;
                n_state   = ST_Q_RD2;
            end
            ST_Q_RD2: begin
                n_mcand = PROD_W'(q_diff);
                n_mplr  = r_dx;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = ST_Q_MUL;
            end
            ST_Q_MUL: begin
                if (r_mplr[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand = r_mcand <<< 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = ST_Q_SUM;
                end
            end
            ST_Q_SUM: begin
                n_res   = q_sat;
                n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!r_o_tvalid || i_m_tready) begin
                    n_o_tvalid = 1'b1;
                    n_o_tdata  = r_res;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < RL1)
        else $error("ring position left the ring");

    a_grid_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_grid >= $past(r_grid))
        else $error("grid time moved backward");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_U_DIV |-> {1'b0, r_rem} < {1'b0, r_t[FRAC_BITS-1:0]})
        else $error("divider remainder not below the fractional offset");

    a_update_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == MODE_UPDATE && !o_m_tvalid)
        |=> !o_m_tvalid)
        else $error("an update item produced a result");
`endif

endmodule

`default_nettype wire

[tb/tb_multi_source_fractional_delay_line_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_source_fractional_delay_line_unit: a scripted
// table of updates and queries, randomized traffic under both delay roundings, then the table's late rows.
// Depends on msfdl_pkg and the unit itself; every delayed value is checked in order.
module tb_multi_source_fractional_delay_line_unit;
    import msfdl_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        late;
        logic        rounding;
        t_mode       mode;
        logic [39:0] t_req;
        logic [3:0]  src;
        logic [31:0] value;
        logic [23:0] dly;
        logic        fixed;
        logic [31:0] want;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [VAL_W-1:0]     o_m_tdata;

    logic signed [31:0] ring_mem [16][256] = '{default: '0};
    logic [23:0]        grid_now   = '0;
    logic [7:0]         ring_pos   = '0;
    logic               round_mode = 1'b0;
    logic [31:0]        due_delayed_values[$];

    int  fail_count     = 0;
    int  values_checked = 0;
    int  updates_sent   = 0;
    int  queries_sent   = 0;
    int  idle_cycles    = 0;
    int  rx_wait        = 0;
    bit  rx_burst       = 1'b0;
    bit  tx_burst       = 1'b0;

    // Fields: late, rounding, mode, time, source, value, delay, typed-in flag, expected.
    t_stim_row script [0:24] = '{
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0000_0000, 4'd0,  32'h0000_0000, 24'h00_0000,
          1'b1, 32'h0000_0000},
        '{1'b0, 1'b0, MODE_QUERY,  40'hFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 24'hFE_0000,
          1'b1, 32'h0000_0000},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0000_0000, 4'd0,  32'h7FFF_FFFF, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0000_0000, 4'd0,  32'h0000_0000, 24'h00_0000,
          1'b1, 32'h7FFF_FFFF},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0000_8000, 4'd0,  32'h8000_0000, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0001_0000, 4'd0,  32'h0000_0000, 24'h00_0000,
          1'b1, 32'h8000_0000},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0000_0001, 4'd1,  32'h7FFF_FFFF, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0000_FFFF, 4'd2,  32'h0001_0000, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0005_0000, 4'd3,  32'h0000_1234, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0002_8000, 4'd3,  32'hFFFF_FFFB, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0005_0000, 4'd3,  32'h0000_0000, 24'h00_0000,
          1'b1, 32'hFFFF_FFFB},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0000_0000, 4'd0,  32'h0000_0000, 24'hFE_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0064_0000, 4'd0,  32'h0000_0000, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0005_8000, 4'd0,  32'h0000_0000, 24'h05_8000,
          1'b0, 32'h0},
        '{1'b0, 1'b1, MODE_QUERY,  40'h00_0005_0000, 4'd0,  32'h0000_0000, 24'h00_8000,
          1'b0, 32'h0},
        '{1'b0, 1'b1, MODE_QUERY,  40'h00_0005_0000, 4'd3,  32'h0000_0000, 24'h00_7FFF,
          1'b1, 32'hFFFF_FFFB},
        '{1'b0, 1'b1, MODE_QUERY,  40'h00_0005_8000, 4'd0,  32'h0000_0000, 24'hFE_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0004_C000, 4'd3,  32'h0000_0000, 24'h00_4000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_UPDATE, 40'h00_0006_4000, 4'd3,  32'h0010_0000, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b0, 1'b0, MODE_QUERY,  40'h00_0006_8000, 4'd3,  32'h0000_0000, 24'h00_C000,
          1'b0, 32'h0},
        '{1'b1, 1'b0, MODE_UPDATE, 40'hFF_FFFF_0000, 4'd4,  32'h1234_5678, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b1, 1'b0, MODE_UPDATE, 40'hFF_FFFF_FFFF, 4'd4,  32'hFFFF_FFFF, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b1, 1'b0, MODE_QUERY,  40'hFF_FFFF_FFFF, 4'd4,  32'h0000_0000, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b1, 1'b0, MODE_UPDATE, 40'h00_0000_0000, 4'd5,  32'h5555_AAAA, 24'h00_0000,
          1'b0, 32'h0},
        '{1'b1, 1'b1, MODE_QUERY,  40'h00_0000_0000, 4'd5,  32'h0000_0000, 24'hFE_0000,
          1'b0, 32'h0}
    };

    multi_source_fractional_delay_line_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Moves the grid forward to the update's time, then extrapolates the new sample to
    // the next grid point, or overwrites the current one when the time is on or before the grid.
    function automatic void apply_update(input logic [39:0] t_req, input logic [3:0] src,
                                         input logic signed [31:0] value);
        logic [23:0] whole;
        logic [7:0]  i0;
        logic [7:0]  i1;
        longint      frac;
        longint      x0;
        longint      q;
        whole = t_req[39:16];
        if (whole > grid_now) begin
            ring_pos = ring_pos - whole[7:0] + grid_now[7:0];
            grid_now = whole;
        end
        frac = longint'(t_req) - longint'(grid_now) * 65536;
        i0   = ring_pos;
        i1   = ring_pos - 8'd1;
        x0   = ring_mem[src][i0];
        if (frac > 0) begin
            q = ((longint'(value) - x0) * 65536) / frac;
            ring_mem[src][i1] = clip32(q + x0);
        end else begin
            ring_mem[src][i0] = value;
        end
    endfunction

    function automatic logic signed [31:0] interpolate_at(input logic [39:0] t_req,
                                                          input logic [3:0] src,
                                                          input logic [23:0] dly);
        longint     d;
        longint     gt;
        longint     lo;
        longint     hi;
        longint     u;
        longint     v;
        longint     k;
        longint     dx;
        longint     y0;
        longint     y1;
        logic [7:0] slot0;
        d = longint'(dly);
        if (round_mode) d = ((d + 32768) >> 16) << 16;
        gt = longint'(grid_now) * 65536;
        lo = gt - 254 * 65536;
        hi = gt + 65536;
        u  = longint'(t_req) - d;
        if (u < lo) u = lo;
        if (u > hi) u = hi;
        v = gt - u;
        k = (v + 131071) / 65536 - 1;
        if (k < 0) begin
            k  = 0;
            dx = 65536;
        end else begin
            dx = k * 65536 - v;
        end
        slot0 = ring_pos + k[7:0];
        y0 = ring_mem[src][slot0];
        y1 = ring_mem[src][slot0 - 8'd1];
        return clip32(y0 + (((y1 - y0) * dx) >>> 16));
    endfunction

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (due_delayed_values.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_rounding(input logic enable);
        drain_results();
        i_cfg_wdata <= enable;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        round_mode = enable;
    endtask

    task automatic send_item(input t_mode mode, input logic [39:0] t_req,
                             input logic [3:0] src, input logic [31:0] value,
                             input logic [23:0] dly, input logic fixed,
                             input logic [31:0] want);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {4'h0, dly, value, src, t_req};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        if (mode == MODE_QUERY) begin
            due_delayed_values.push_back(fixed ? want : interpolate_at(t_req, src, dly));
            queries_sent++;
        end else begin
            apply_update(t_req, src, value);
            updates_sent++;
        end
    endtask

    task automatic play_row(input t_stim_row row);
        if (row.rounding != round_mode) set_rounding(row.rounding);
        send_item(row.mode, row.t_req, row.src, row.value, row.dly, row.fixed, row.want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_delayed_values.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected delayed value %h at %0t", o_m_tdata, $time);
                end else begin
                    if (o_m_tdata !== due_delayed_values[0]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("delayed_value mismatch: expected %h, got %h at %0t",
                                     due_delayed_values[0], o_m_tdata, $time);
                    end
                    void'(due_delayed_values.pop_front());
                    values_checked++;
                end
                if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_mode       mode;
        int unsigned pick;
        int unsigned back;
        logic [39:0] t_req;
        logic [39:0] t_now;
        logic [23:0] dly;
        logic [31:0] value;
        logic [3:0]  src;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_rounding(1'b0);
        foreach (script[i]) if (!script[i].late) play_row(script[i]);

        t_now = {grid_now, 16'h0};
        for (int phase = 0; phase < 4; phase++) begin
            set_rounding(phase % 2 == 0);
            for (int n = 0; n < 225; n++) begin
                mode  = $urandom_range(0, 1) ? MODE_QUERY : MODE_UPDATE;
                src   = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
                value = ($urandom_range(0, 2) == 0) ? $urandom
                        : 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
                pick  = $urandom_range(0, 99);
                if (pick < 70) dly = 24'($urandom_range(0, 24'h0A_0000));
                else if (pick < 90) dly = 24'($urandom_range(0, 24'hFE_0000));
                else if (pick < 95) dly = 24'hFE_0000;
                else dly = {8'($urandom_range(0, 253)), 16'h8000};
                if (mode == MODE_QUERY) begin
                    if ($urandom_range(0, 9) == 0) t_req = {8'($urandom), 32'($urandom)};
                    else t_req = t_now + $urandom_range(0, 65535);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        t_req = t_now + $urandom_range(0, 131072);
                    end else if (pick < 65) begin
                        t_req = {t_now[39:16] + 24'($urandom_range(1, 3)), 16'h0};
                    end else if (pick < 75) begin
                        t_req = {grid_now, 16'h0};
                        back  = $urandom_range(0, 196608);
                        t_req = (t_req > back) ? t_req - back : '0;
                    end else if (pick < 80) begin
                        t_req = t_now + {8'h0, 16'($urandom_range(257, 600)), 16'($urandom)};
                    end else begin
                        t_req = {grid_now, 16'($urandom_range(1, 255))};
                    end
                    if (t_req > t_now) t_now = t_req;
                end
                send_item(mode, t_req, src, value, dly, 1'b0, '0);
            end
        end

        foreach (script[i]) if (script[i].late) play_row(script[i]);
        drain_results();
        $display("Checked %0d delayed values from %0d updates and %0d queries,",
                 values_checked, updates_sent, queries_sent);
        $display("with delay rounding off and on, saturation, clamping and long grid jumps.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/msfdl_pkg.sv
rtl/multi_source_fractional_delay_line_unit.sv
tb/tb_multi_source_fractional_delay_line_unit.sv
